// File: hdl/gap_pkg.sv
// Package with control word layout, step codes and the sequencer program.
`timescale 1ns / 1ps

package gap_pkg;

    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_G_TEST    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_G_START   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_G_WAIT    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_G_SWAP    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_P_INIT    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_P_TEST    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_P_START   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_P_WAIT    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_P_CHECK   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_P_NEXT    = 4'd11;
    localparam logic [STEP_W-1:0] STEP_OUT_GCD   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_OUT_PRIME = 4'd13;
    localparam logic [STEP_W-1:0] STEP_OUT_NP    = 4'd14;

    localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
    localparam logic [OP_W-1:0] OP_START_GCD   = 4'd1;
    localparam logic [OP_W-1:0] OP_START_PRIME = 4'd2;
    localparam logic [OP_W-1:0] OP_SWAP        = 4'd3;
    localparam logic [OP_W-1:0] OP_INIT_D      = 4'd4;
    localparam logic [OP_W-1:0] OP_STEP_D      = 4'd5;
    localparam logic [OP_W-1:0] OP_OUT_GCD     = 4'd6;
    localparam logic [OP_W-1:0] OP_OUT_PRIME   = 4'd7;
    localparam logic [OP_W-1:0] OP_OUT_NP      = 4'd8;

    localparam logic [COND_W-1:0] COND_NEXT     = 4'd0;
    localparam logic [COND_W-1:0] COND_JUMP     = 4'd1;
    localparam logic [COND_W-1:0] COND_MODE     = 4'd2;
    localparam logic [COND_W-1:0] COND_Y_ZERO   = 4'd3;
    localparam logic [COND_W-1:0] COND_LT2      = 4'd4;
    localparam logic [COND_W-1:0] COND_SQ_GT    = 4'd5;
    localparam logic [COND_W-1:0] COND_REM_ZERO = 4'd6;
    localparam logic [COND_W-1:0] COND_WAIT_IN  = 4'd7;
    localparam logic [COND_W-1:0] COND_WAIT_DIV = 4'd8;
    localparam logic [COND_W-1:0] COND_WAIT_OUT = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t program_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            STEP_IDLE:      w = '{OP_NOP,         COND_WAIT_IN,  STEP_IDLE};
            STEP_DISPATCH:  w = '{OP_NOP,         COND_MODE,     STEP_P_INIT};
            STEP_G_TEST:    w = '{OP_NOP,         COND_Y_ZERO,   STEP_OUT_GCD};
            STEP_G_START:   w = '{OP_START_GCD,   COND_NEXT,     STEP_IDLE};
            STEP_G_WAIT:    w = '{OP_NOP,         COND_WAIT_DIV, STEP_IDLE};
            STEP_G_SWAP:    w = '{OP_SWAP,        COND_JUMP,     STEP_G_TEST};
            STEP_P_INIT:    w = '{OP_INIT_D,      COND_LT2,      STEP_OUT_NP};
            STEP_P_TEST:    w = '{OP_NOP,         COND_SQ_GT,    STEP_OUT_PRIME};
            STEP_P_START:   w = '{OP_START_PRIME, COND_NEXT,     STEP_IDLE};
            STEP_P_WAIT:    w = '{OP_NOP,         COND_WAIT_DIV, STEP_IDLE};
            STEP_P_CHECK:   w = '{OP_NOP,         COND_REM_ZERO, STEP_OUT_NP};
            STEP_P_NEXT:    w = '{OP_STEP_D,      COND_JUMP,     STEP_P_TEST};
            STEP_OUT_GCD:   w = '{OP_OUT_GCD,     COND_WAIT_OUT, STEP_IDLE};
            STEP_OUT_PRIME: w = '{OP_OUT_PRIME,   COND_WAIT_OUT, STEP_IDLE};
            STEP_OUT_NP:    w = '{OP_OUT_NP,      COND_WAIT_OUT, STEP_IDLE};
            default:        w = '{OP_NOP,         COND_JUMP,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/gap_rem_unit.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module gap_rem_unit #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[W-1:0];
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/gcd_and_primality_unit.sv
// gcd runs one remainder per Euclid step until y is zero; primality tries divisors from two
// upward while the divisor squared does not exceed the value, and stops at the first one that
// divides; values below two are reported not prime without a division.
// The bit-serial remainder unit serves every Euclid step or trial divisor.
// One item at a time; the next input transfer can come in the cycle after the result loads.
// Reset clears the sequencer, the remainder unit control and the output valid.
`timescale 1ns / 1ps

module gcd_and_primality_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [OPERAND_WIDTH-1:0] operand_a,
    input  logic [OPERAND_WIDTH-1:0] operand_b,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [OPERAND_WIDTH-1:0] gcd_value,
    output logic                     prime_flag
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = W / 2 + 2;
    localparam int SW = W + 2;

    logic [gap_pkg::STEP_W-1:0] pc_reg, pc_next;
    gap_pkg::ctrl_word_t        cw;

    logic          mode_reg, mode_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [DW-1:0] d_reg, d_next;
    logic [SW-1:0] sq_reg, sq_next;

    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  gcd_value_reg, gcd_value_next;
    logic          prime_flag_reg, prime_flag_next;

    logic          in_xfer;
    logic          out_free;
    logic          taken;
    logic          div_start;
    logic          div_done;
    logic [W-1:0]  div_divisor;
    logic [W-1:0]  rem;

    assign cw       = gap_pkg::program_rom(pc_reg);
    assign in_stall = (pc_reg != gap_pkg::STEP_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign div_start   = (cw.op == gap_pkg::OP_START_GCD) || (cw.op == gap_pkg::OP_START_PRIME);
    assign div_divisor = (cw.op == gap_pkg::OP_START_GCD) ? y_reg : W'(d_reg);

    gap_rem_unit #(
        .W(W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (x_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (rem)
    );

    always_comb
    begin
        unique case (cw.cond)
            gap_pkg::COND_MODE:     taken = mode_reg;
            gap_pkg::COND_Y_ZERO:   taken = (y_reg == '0);
            gap_pkg::COND_LT2:      taken = (x_reg < W'(2));
            gap_pkg::COND_SQ_GT:    taken = (sq_reg > SW'(x_reg));
            gap_pkg::COND_REM_ZERO: taken = (rem == '0);
            gap_pkg::COND_JUMP:     taken = 1'b1;
            default:                taken = 1'b0;
        endcase
    end

    always_comb
    begin
        priority case (cw.cond)
            gap_pkg::COND_WAIT_IN:  pc_next = in_xfer ? pc_reg + 1'b1 : pc_reg;
            gap_pkg::COND_WAIT_DIV: pc_next = div_done ? pc_reg + 1'b1 : pc_reg;
            gap_pkg::COND_WAIT_OUT: pc_next = out_free ? cw.target : pc_reg;
            default:                pc_next = taken ? cw.target : pc_reg + 1'b1;
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        out_valid_next  = out_valid_reg && out_stall;
        gcd_value_next  = gcd_value_reg;
        prime_flag_next = prime_flag_reg;
        if (in_xfer)
        begin
            mode_next = mode;
            x_next    = operand_a;
            y_next    = operand_b;
        end
        unique case (cw.op)
            gap_pkg::OP_SWAP:
            begin
                x_next = y_reg;
                y_next = rem;
            end
            gap_pkg::OP_INIT_D:
            begin
                d_next  = DW'(2);
                sq_next = SW'(4);
            end
            gap_pkg::OP_STEP_D:
            begin
                d_next  = d_reg + 1'b1;
                sq_next = sq_reg + SW'({d_reg, 1'b1});
            end
            gap_pkg::OP_OUT_GCD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    gcd_value_next  = x_reg;
                    prime_flag_next = 1'b0;
                end
            end
            gap_pkg::OP_OUT_PRIME, gap_pkg::OP_OUT_NP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    gcd_value_next  = '0;
                    prime_flag_next = (cw.op == gap_pkg::OP_OUT_PRIME);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= gap_pkg::STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        d_reg          <= d_next;
        sq_reg         <= sq_next;
        gcd_value_reg  <= gcd_value_next;
        prime_flag_reg <= prime_flag_next;
    end

    assign out_valid  = out_valid_reg;
    assign gcd_value  = gcd_value_reg;
    assign prime_flag = prime_flag_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (pc_reg == gap_pkg::STEP_G_WAIT) || (pc_reg == gap_pkg::STEP_P_WAIT))
        else $error("remainder done outside a wait step");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pc_reg) == gap_pkg::STEP_OUT_GCD)
            || ($past(pc_reg) == gap_pkg::STEP_OUT_PRIME)
            || ($past(pc_reg) == gap_pkg::STEP_OUT_NP))
        else $error("result loaded outside an output step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && prime_flag_reg) |-> (gcd_value_reg == '0))
        else $error("prime result carries a nonzero gcd");

endmodule
